@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/stt_pkg.sv @@
package stt_pkg;

    // Token kinds
    localparam logic [5:0] KIND_END  = 6'd0;
    localparam logic [5:0] KIND_SYM  = 6'd1;
    localparam logic [5:0] KIND_INT  = 6'd2;
    localparam logic [5:0] KIND_BOOL = 6'd3;
    localparam logic [5:0] KIND_ERR  = 6'd50;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNICODE  = 2'd1;
    localparam logic [1:0] ERR_CMT_END  = 2'd2;
    localparam logic [1:0] ERR_SPECIAL  = 2'd3;

    // Register index of source_id (bit 2 of the byte address)
    localparam logic REG_SOURCE_ID = 1'b0;

    // Maximum words produced by one input byte
    localparam int PUSH_MAX = 3;

    // Open token being accumulated
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_SYM,
        ACC_INT
    } acc_kind_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] kind;
        logic       val;
    } kw_hit_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_sym_start(input logic [7:0] c);
        return is_alpha(c) || c == 8'h5F;
    endfunction

    function automatic logic is_sym_char(input logic [7:0] c);
        return is_sym_start(c) || is_digit(c);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
               c == 8'h0C || c == 8'h0D;
    endfunction

    // Single-character operator kind, zero if none
    function automatic logic [5:0] solo_kind(input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        case (c)
            8'h28: k = 6'd4;   8'h29: k = 6'd5;   8'h7B: k = 6'd6;
            8'h7D: k = 6'd7;   8'h5B: k = 6'd8;   8'h5D: k = 6'd9;
            8'h2B: k = 6'd10;  8'h2D: k = 6'd11;  8'h2A: k = 6'd12;
            8'h2F: k = 6'd13;  8'h25: k = 6'd14;  8'h26: k = 6'd17;
            8'h7C: k = 6'd18;  8'h5E: k = 6'd19;  8'h7E: k = 6'd20;
            8'h21: k = 6'd23;  8'h3C: k = 6'd26;  8'h3E: k = 6'd28;
            8'h3D: k = 6'd30;  8'h3F: k = 6'd33;  8'h3A: k = 6'd34;
            8'h3B: k = 6'd37;  8'h2E: k = 6'd38;  8'h2C: k = 6'd40;
            8'h24: k = 6'd41;  8'h23: k = 6'd42;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic needs_pair(input logic [7:0] c);
        return c == 8'h2B || c == 8'h2D || c == 8'h26 || c == 8'h7C || c == 8'h21 ||
               c == 8'h3C || c == 8'h3E || c == 8'h3D || c == 8'h3A || c == 8'h2E;
    endfunction

    // Two-character operator kind, zero if the pair is not an operator
    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] b);
        logic [5:0] k;
        k = 6'd0;
        case (p)
            8'h2B: k = (b == 8'h3D) ? 6'd31 : ((b == 8'h2B) ? 6'd15 : 6'd0);
            8'h2D: k = (b == 8'h3E) ? 6'd36 : ((b == 8'h3D) ? 6'd32 :
                       ((b == 8'h2D) ? 6'd16 : 6'd0));
            8'h26: k = (b == 8'h26) ? 6'd22 : 6'd0;
            8'h7C: k = (b == 8'h7C) ? 6'd21 : 6'd0;
            8'h21: k = (b == 8'h3D) ? 6'd25 : 6'd0;
            8'h3C: k = (b == 8'h3D) ? 6'd27 : 6'd0;
            8'h3E: k = (b == 8'h3D) ? 6'd29 : 6'd0;
            8'h3D: k = (b == 8'h3D) ? 6'd24 : 6'd0;
            8'h3A: k = (b == 8'h3A) ? 6'd35 : 6'd0;
            8'h2E: k = (b == 8'h5E) ? 6'd39 : 6'd0;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    // Keyword match; first character sits in the low byte
    function automatic kw_hit_t kw_lookup(input logic [55:0] chars, input logic [3:0] len);
        kw_hit_t r;
        r = '{hit: 1'b1, kind: KIND_SYM, val: 1'b0};
        if (len == 4'd2 && chars == 56'h6e66)                r.kind = 6'd43;
        else if (len == 4'd2 && chars == 56'h6669)           r.kind = 6'd47;
        else if (len == 4'd4 && chars == 56'h65736c65)       r.kind = 6'd48;
        else if (len == 4'd6 && chars == 56'h6e7275746572)   r.kind = 6'd46;
        else if (len == 4'd6 && chars == 56'h746375727473)   r.kind = 6'd44;
        else if (len == 4'd7 && chars == 56'h6e676965726f66) r.kind = 6'd45;
        else if (len == 4'd5 && chars == 56'h656c696877)     r.kind = 6'd49;
        else if (len == 4'd4 && chars == 56'h65757274) begin
            r.kind = KIND_BOOL;
            r.val  = 1'b1;
        end else if (len == 4'd5 && chars == 56'h65736c6166) begin
            r.kind = KIND_BOOL;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hdl/source_text_tokenizer.sv @@
// Source text tokenizer: takes one byte of UTF-8 text per word on s_ and returns
// tokens on m_, each with line, column and the source_id register. A byte is taken
// every cycle while the result queue has room for three words; the queue drains one
// token per cycle while m_tready is high. The tokens of an accepted byte are written
// to the queue and leave from its head. A word with tlast set ends the text: pending
// tokens are flushed, the end token follows, and the scanner returns to line one. The
// user writes source_id through the APB port while idle; the block does not enforce it.
`include "assert_macros.svh"

module source_text_tokenizer #(
    parameter int LINE_BITS       = 24,
    parameter int OFFSET_BITS     = 32,
    parameter int SYMBOL_LEN_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input byte stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // text_byte
    input  logic                 s_tlast,   // end_of_text
    // Token stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // error_code, int_value, bool_value, symbol_start, symbol_length,
    // line_number, column_number, token_file, zero fill
    output logic [((2 + 31 + 1 + OFFSET_BITS + SYMBOL_LEN_BITS + LINE_BITS + 17 + 16
                    + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [5:0]           m_tuser,   // token_kind
    output logic                 m_tlast,   // last_result
    // Configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import stt_pkg::*;

    localparam int DEPTH   = 8;
    localparam int LVL_W   = $clog2(DEPTH + 1);
    localparam int DATA_B  = 2 + 31 + 1 + OFFSET_BITS + SYMBOL_LEN_BITS + LINE_BITS + 17 + 16;
    localparam int TDATA_W = ((DATA_B + 7) / 8) * 8;

    typedef struct packed {
        logic                       last;
        logic [16:0]                col;
        logic [LINE_BITS-1:0]       line;
        logic [SYMBOL_LEN_BITS-1:0] len;
        logic [OFFSET_BITS-1:0]     start;
        logic                       bval;
        logic [30:0]                ival;
        logic [1:0]                 err;
        logic [5:0]                 kind;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    logic [15:0]              src_id_reg;
    logic                     take;
    logic [2:0][REC_W-1:0]    res_data;
    logic [1:0]               res_cnt;
    logic                     room;
    logic [LVL_W-1:0]         level;
    logic [REC_W-1:0]         head_word;
    rec_t                     head;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SOURCE_ID) ? {16'd0, src_id_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_id_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SOURCE_ID) begin
            src_id_reg <= pwdata[15:0];
        end
    end

    // Front: scan and classify
    assign s_tready = room;
    assign take     = s_tvalid && s_tready;

    stt_front #(
        .LINE_BITS       (LINE_BITS),
        .OFFSET_BITS     (OFFSET_BITS),
        .SYMBOL_LEN_BITS (SYMBOL_LEN_BITS),
        .REC_W           (REC_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .res_data    (res_data),
        .res_cnt     (res_cnt)
    );

    // Back: queue tokens and hand them out
    stt_queue #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_data (res_data),
        .push_cnt  (res_cnt),
        .room      (room),
        .level     (level),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head_word)
    );

    assign head    = rec_t'(head_word);
    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = TDATA_W'({src_id_reg, head.col, head.line, head.len, head.start,
                               head.bval, head.ival, head.err});

    `ASSERT_ALWAYS(a_level_bound, aclk, aresetn, level <= LVL_W'(DEPTH),
        "result queue overflow")
    `ASSERT_IMPLIES(a_end_last, aclk, aresetn, m_tvalid && head.kind == KIND_END,
        head.last && head.col == 17'h1FFFF, "end token without tlast or column -1")
    `ASSERT_IMPLIES(a_err_code, aclk, aresetn, m_tvalid,
        (head.kind == KIND_ERR) == (head.err != ERR_NONE), "error code mismatch")
    `ASSERT_IMPLIES(a_take_room, aclk, aresetn, take,
        level <= LVL_W'(DEPTH - PUSH_MAX), "byte taken without queue room")

endmodule

@@ hdl/stt_front.sv @@
module stt_front #(
    parameter int LINE_BITS       = 24,
    parameter int OFFSET_BITS     = 32,
    parameter int SYMBOL_LEN_BITS = 8,
    parameter int REC_W           = 1 + 17 + LINE_BITS + SYMBOL_LEN_BITS + OFFSET_BITS + 40
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     take,
    input  logic [7:0]               text_byte,
    input  logic                     end_of_text,
    output logic [2:0][REC_W-1:0]    res_data,
    output logic [1:0]               res_cnt
);
    import stt_pkg::*;

    typedef struct packed {
        logic                       last;
        logic [16:0]                col;
        logic [LINE_BITS-1:0]       line;
        logic [SYMBOL_LEN_BITS-1:0] len;
        logic [OFFSET_BITS-1:0]     start;
        logic                       bval;
        logic [30:0]                ival;
        logic [1:0]                 err;
        logic [5:0]                 kind;
    } rec_t;

    localparam logic [LINE_BITS-1:0]       LINE_MAX = '1;
    localparam logic [SYMBOL_LEN_BITS-1:0] SLEN_MAX = '1;
    localparam logic [15:0]                COL_MAX  = 16'hFFFF;
    localparam logic [34:0]                INT_SAT  = 35'h7FFFFFFF;

    // Scanner state
    logic [LINE_BITS-1:0]       line_reg, line_next;
    logic [15:0]                col_reg, col_next;
    logic [OFFSET_BITS-1:0]     off_reg, off_next;
    logic signed [7:0]          depth_reg, depth_next;
    logic                       lc_reg, lc_next;
    logic                       pend_v_reg, pend_v_next;
    logic [7:0]                 pend_reg, pend_next;
    logic [1:0]                 u_left_reg, u_left_next;
    logic [15:0]                u_code_reg, u_code_next;
    acc_kind_t                  acc_reg, acc_next;
    logic [55:0]                kw_reg, kw_next;
    logic [SYMBOL_LEN_BITS-1:0] slen_reg, slen_next;
    logic [30:0]                num_reg, num_next;
    logic [LINE_BITS-1:0]       st_line_reg, st_line_next;
    logic [15:0]                st_col_reg, st_col_next;
    logic [OFFSET_BITS-1:0]     st_off_reg, st_off_next;

    // Words built from the current registers
    logic      close_has;
    rec_t      close_rec;
    kw_hit_t   kw_hit;
    logic [3:0] kw_len;
    logic      in_cmt_reg;

    // Working values of the step
    rec_t [2:0]             res;
    logic [1:0]             n;
    logic                   do_fresh, do_char;
    logic [7:0]             ch;
    logic [OFFSET_BITS-1:0] here;
    logic [5:0]             pk, sk;
    logic [15:0]            cp;
    logic [34:0]            prod;

    function automatic rec_t make_rec(
        input logic [5:0]                 kind,
        input logic [1:0]                 err,
        input logic [30:0]                ival,
        input logic                       bval,
        input logic [OFFSET_BITS-1:0]     start,
        input logic [SYMBOL_LEN_BITS-1:0] len,
        input logic [LINE_BITS-1:0]       line,
        input logic [16:0]                col
    );
        rec_t r;
        r.last  = 1'b0;
        r.kind  = kind;
        r.err   = err;
        r.ival  = ival;
        r.bval  = bval;
        r.start = start;
        r.len   = len;
        r.line  = line;
        r.col   = col;
        return r;
    endfunction

    // Close an open symbol or number
    assign in_cmt_reg = (depth_reg > 8'sd0) || lc_reg;
    assign kw_len     = (slen_reg > SYMBOL_LEN_BITS'(7)) ? 4'd0 : 4'(slen_reg);
    assign kw_hit     = kw_lookup(kw_reg, kw_len);
    assign close_has  = (acc_reg != ACC_NONE);

    always_comb begin
        if (acc_reg == ACC_INT) begin
            close_rec = make_rec(KIND_INT, ERR_NONE, num_reg, 1'b0, '0, '0,
                                 st_line_reg, {1'b0, st_col_reg});
        end else if (kw_hit.hit) begin
            close_rec = make_rec(kw_hit.kind, ERR_NONE, '0, kw_hit.val, '0, '0,
                                 st_line_reg, {1'b0, st_col_reg});
        end else begin
            close_rec = make_rec(KIND_SYM, ERR_NONE, '0, 1'b0, st_off_reg, slen_reg,
                                 st_line_reg, {1'b0, st_col_reg});
        end
    end

    // Scan one byte
    always_comb begin
        line_next    = line_reg;
        col_next     = col_reg;
        off_next     = off_reg;
        depth_next   = depth_reg;
        lc_next      = lc_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        u_left_next  = u_left_reg;
        u_code_next  = u_code_reg;
        acc_next     = acc_reg;
        kw_next      = kw_reg;
        slen_next    = slen_reg;
        num_next     = num_reg;
        st_line_next = st_line_reg;
        st_col_next  = st_col_reg;
        st_off_next  = st_off_reg;
        res          = '0;
        n            = 2'd0;
        do_fresh     = 1'b0;
        do_char      = 1'b0;
        ch           = text_byte;
        here         = off_reg;
        pk           = pair_kind(pend_reg, text_byte);
        sk           = solo_kind(pend_reg);
        cp           = '0;
        prod         = {4'd0, num_reg} * 35'd10 + 35'(text_byte - 8'h30);

        if (end_of_text) begin
            // Flush pending operator, open token and partial sequence
            if (pend_v_reg && !in_cmt_reg) begin
                res[n] = make_rec(sk, ERR_NONE, '0, 1'b0, '0, '0,
                                  st_line_reg, {1'b0, st_col_reg});
                n = n + 2'd1;
            end
            if (close_has) begin
                res[n] = close_rec;
                n = n + 2'd1;
            end
            if (u_left_reg != 2'd0) begin
                res[n] = make_rec(KIND_ERR, ERR_UNICODE, '0, 1'b0, '0, '0,
                                  line_reg, {1'b0, col_reg});
                n = n + 2'd1;
            end
            res[n] = make_rec(KIND_END, ERR_NONE, '0, 1'b0, '0, '0, line_reg, '1);
            n = n + 2'd1;
            line_next    = LINE_BITS'(1);
            col_next     = '0;
            off_next     = '0;
            depth_next   = '0;
            lc_next      = 1'b0;
            pend_v_next  = 1'b0;
            pend_next    = '0;
            u_left_next  = '0;
            u_code_next  = '0;
            acc_next     = ACC_NONE;
            kw_next      = '0;
            slen_next    = '0;
            num_next     = '0;
            st_line_next = '0;
            st_col_next  = '0;
            st_off_next  = '0;
        end else begin
            if (u_left_reg != 2'd0) begin
                // Continue a multi-byte character
                off_next    = off_reg + OFFSET_BITS'(1);
                u_code_next = {u_code_reg[9:0], text_byte[5:0]};
                u_left_next = u_left_reg - 2'd1;
                if (u_left_next == 2'd0) begin
                    cp   = u_code_next;
                    here = off_next;
                    if (cp == 16'h00B4 || cp == 16'h2018 || cp == 16'h2019) begin
                        do_char = 1'b1;
                        ch      = 8'h27;
                    end else if (cp == 16'h201C || cp == 16'h201D || cp == 16'h201F ||
                                 cp == 16'h275D || cp == 16'h275E) begin
                        do_char = 1'b1;
                        ch      = 8'h22;
                    end else begin
                        res[n] = make_rec(KIND_ERR, ERR_UNICODE, '0, 1'b0, '0, '0,
                                          line_reg, {1'b0, col_reg});
                        n = n + 2'd1;
                    end
                end
            end else if (pend_v_reg) begin
                // Resolve the pending operator against this byte
                pend_v_next = 1'b0;
                if (pend_reg == 8'h2F && text_byte == 8'h2A) begin
                    if (depth_reg != 8'sd127) depth_next = depth_reg + 8'sd1;
                    if (col_reg != COL_MAX) col_next = col_reg + 16'd1;
                    off_next = off_reg + OFFSET_BITS'(1);
                end else if (pend_reg == 8'h2F && text_byte == 8'h2F) begin
                    lc_next = 1'b1;
                    if (col_reg != COL_MAX) col_next = col_reg + 16'd1;
                    off_next = off_reg + OFFSET_BITS'(1);
                end else if (pend_reg == 8'h2A && text_byte == 8'h2F) begin
                    if (depth_reg != -8'sd128) depth_next = depth_reg - 8'sd1;
                    if (col_reg != COL_MAX) col_next = col_reg + 16'd1;
                    off_next = off_reg + OFFSET_BITS'(1);
                    if (depth_next < 8'sd0) begin
                        res[n] = make_rec(KIND_ERR, ERR_CMT_END, '0, 1'b0, '0, '0,
                                          line_reg, {1'b0, col_next});
                        n = n + 2'd1;
                    end
                end else if (pk != 6'd0) begin
                    res[n] = make_rec(pk, ERR_NONE, '0, 1'b0, '0, '0,
                                      st_line_reg, {1'b0, st_col_reg});
                    n = n + 2'd1;
                    if (col_reg != COL_MAX) col_next = col_reg + 16'd1;
                    off_next = off_reg + OFFSET_BITS'(1);
                end else begin
                    if (!in_cmt_reg) begin
                        res[n] = make_rec(sk, ERR_NONE, '0, 1'b0, '0, '0,
                                          st_line_reg, {1'b0, st_col_reg});
                        n = n + 2'd1;
                    end
                    do_fresh = 1'b1;
                end
            end else if (acc_reg == ACC_SYM) begin
                // Extend or close a symbol
                if (is_sym_char(text_byte)) begin
                    for (int j = 0; j < 7; j++) begin
                        if (slen_reg == SYMBOL_LEN_BITS'(j)) kw_next[8*j +: 8] = text_byte;
                    end
                    if (slen_reg != SLEN_MAX) slen_next = slen_reg + SYMBOL_LEN_BITS'(1);
                    if (col_reg != COL_MAX) col_next = col_reg + 16'd1;
                    off_next = off_reg + OFFSET_BITS'(1);
                end else begin
                    res[n] = close_rec;
                    n = n + 2'd1;
                    acc_next = ACC_NONE;
                    do_fresh = 1'b1;
                end
            end else if (acc_reg == ACC_INT) begin
                // Extend or close a number
                if (is_digit(text_byte)) begin
                    num_next = (prod > INT_SAT) ? 31'h7FFFFFFF : prod[30:0];
                    if (col_reg != COL_MAX) col_next = col_reg + 16'd1;
                    off_next = off_reg + OFFSET_BITS'(1);
                end else begin
                    res[n] = close_rec;
                    n = n + 2'd1;
                    acc_next = ACC_NONE;
                    do_fresh = 1'b1;
                end
            end else begin
                do_fresh = 1'b1;
            end

            // Fresh byte: newline, lead byte or plain character
            if (do_fresh) begin
                here = off_reg;
                off_next = off_reg + OFFSET_BITS'(1);
                if (text_byte == 8'h0A) begin
                    col_next = '0;
                    if (line_reg != LINE_MAX) line_next = line_reg + LINE_BITS'(1);
                    lc_next = 1'b0;
                end else begin
                    if (col_reg != COL_MAX) col_next = col_reg + 16'd1;
                    if (text_byte[7]) begin
                        if (text_byte[7:5] == 3'b110) begin
                            u_left_next = 2'd1;
                            u_code_next = {11'd0, text_byte[4:0]};
                        end else if (text_byte[7:4] == 4'b1110) begin
                            u_left_next = 2'd2;
                            u_code_next = {12'd0, text_byte[3:0]};
                        end else begin
                            res[n] = make_rec(KIND_ERR, ERR_UNICODE, '0, 1'b0, '0, '0,
                                              line_next, {1'b0, col_next});
                            n = n + 2'd1;
                        end
                    end else begin
                        do_char = 1'b1;
                        ch      = text_byte;
                    end
                end
            end

            // Classify one character
            if (do_char && !is_space(ch)) begin
                if (ch == 8'h2F || ch == 8'h2A) begin
                    pend_v_next  = 1'b1;
                    pend_next    = ch;
                    st_line_next = line_next;
                    st_col_next  = col_next;
                    st_off_next  = here;
                end else if ((depth_next > 8'sd0) || lc_next) begin
                    pend_v_next = pend_v_next;
                end else if (is_sym_start(ch)) begin
                    acc_next     = ACC_SYM;
                    kw_next      = {48'd0, ch};
                    slen_next    = SYMBOL_LEN_BITS'(1);
                    st_line_next = line_next;
                    st_col_next  = col_next;
                    st_off_next  = here;
                end else if (is_digit(ch)) begin
                    acc_next     = ACC_INT;
                    num_next     = 31'(ch - 8'h30);
                    st_line_next = line_next;
                    st_col_next  = col_next;
                    st_off_next  = here;
                end else if (needs_pair(ch)) begin
                    pend_v_next  = 1'b1;
                    pend_next    = ch;
                    st_line_next = line_next;
                    st_col_next  = col_next;
                    st_off_next  = here;
                end else if (solo_kind(ch) != 6'd0) begin
                    res[n] = make_rec(solo_kind(ch), ERR_NONE, '0, 1'b0, '0, '0,
                                      line_next, {1'b0, col_next});
                    n = n + 2'd1;
                end else begin
                    res[n] = make_rec(KIND_ERR, ERR_SPECIAL, '0, 1'b0, '0, '0,
                                      line_next, {1'b0, col_next});
                    n = n + 2'd1;
                end
            end
        end

        // Mark the final word of this byte
        for (int i = 0; i < PUSH_MAX; i++) begin
            res[i].last = (2'(i + 1) == n);
        end
    end

    assign res_data = res;
    assign res_cnt  = take ? n : 2'd0;

    // Advance state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= LINE_BITS'(1);
            col_reg     <= '0;
            off_reg     <= '0;
            depth_reg   <= '0;
            lc_reg      <= 1'b0;
            pend_v_reg  <= 1'b0;
            u_left_reg  <= '0;
            acc_reg     <= ACC_NONE;
            slen_reg    <= '0;
            kw_reg      <= '0;
            num_reg     <= '0;
            st_line_reg <= '0;
            st_col_reg  <= '0;
            st_off_reg  <= '0;
            pend_reg    <= '0;
            u_code_reg  <= '0;
        end else if (take) begin
            line_reg    <= line_next;
            col_reg     <= col_next;
            off_reg     <= off_next;
            depth_reg   <= depth_next;
            lc_reg      <= lc_next;
            pend_v_reg  <= pend_v_next;
            u_left_reg  <= u_left_next;
            acc_reg     <= acc_next;
            slen_reg    <= slen_next;
            kw_reg      <= kw_next;
            num_reg     <= num_next;
            st_line_reg <= st_line_next;
            st_col_reg  <= st_col_next;
            st_off_reg  <= st_off_next;
            pend_reg    <= pend_next;
            u_code_reg  <= u_code_next;
        end
    end

endmodule

@@ hdl/stt_queue.sv @@
module stt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [2:0][WIDTH-1:0]        push_data,
    input  logic [1:0]                   push_cnt,
    output logic                         room,
    output logic [$clog2(DEPTH+1)-1:0]   level,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [WIDTH-1:0]             out_data
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              pop;

    // Drain one word per cycle from the head while out_ready is high
    assign out_valid = (level_reg != '0);
    assign out_data  = mem_reg[head_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (level_reg <= LVL_W'(DEPTH - PUSH_MAX));
    assign level     = level_reg;

    assign head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
    assign tail_next  = tail_reg + PTR_W'(push_cnt);
    assign level_next = level_reg + LVL_W'(push_cnt) - LVL_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    // Write up to three words at the tail
    always_ff @(posedge aclk) begin
        for (int i = 0; i < PUSH_MAX; i++) begin
            if (2'(i) < push_cnt) mem_reg[tail_reg + PTR_W'(i)] <= push_data[i];
        end
    end

endmodule

@@ tb/sv/source_text_tokenizer_checker.sv @@
module source_text_tokenizer_checker
    import stt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [5:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fails,
    output int           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;
    localparam logic [15:0] COL_MAX   = 16'hFFFF;
    localparam logic [30:0] INT_MAX   = 31'h7FFFFFFF;
    localparam logic [7:0]  SLEN_MAX  = 8'hFF;
    localparam logic [16:0] COL_END   = 17'h1FFFF;
    localparam logic [7:0]  CH_NL     = 8'h0A;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_APOS   = 8'h27;
    localparam logic [7:0]  CH_QUOTE  = 8'h22;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [30:0] ival;
        logic        bval;
        logic [31:0] sstart;
        logic [7:0]  slen;
        logic [23:0] line;
        logic [16:0] col;
        logic [15:0] file;
        logic        last;
    } token_t;

    token_t token_q[$];
    token_t step_tokens[$];

    // scanner copy
    logic [15:0] src_id;
    logic [23:0] line_cnt;
    logic [15:0] col_cnt;
    logic [31:0] offset;
    int          depth;
    logic        in_line_cmt;
    logic        pend_vld;
    logic [7:0]  pend_chr;
    int          utf_left;
    logic [15:0] utf_code;
    acc_kind_t   open_kind;
    logic [7:0]  word_chars[7];
    logic [7:0]  word_len;
    logic [30:0] num_acc;
    logic [23:0] st_line;
    logic [15:0] st_col;
    logic [31:0] st_off;

    assign outstanding = token_q.size();

    function automatic bit alpha_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit ident_first(logic [7:0] c);
        return alpha_c(c) || c == "_";
    endfunction
    function automatic bit blank_c(logic [7:0] c);
        return c == " " || c == 8'h09 || c == CH_NL || c == 8'h0B || c == 8'h0C ||
               c == 8'h0D;
    endfunction

    function automatic logic [5:0] single_op(logic [7:0] c);
        case (c)
            "(": return 4;  ")": return 5;  "{": return 6;  "}": return 7;
            "[": return 8;  "]": return 9;  "+": return 10; "-": return 11;
            "*": return 12; "/": return 13; "%": return 14; "&": return 17;
            "|": return 18; "^": return 19; "~": return 20; "!": return 23;
            "<": return 26; ">": return 28; "=": return 30; "?": return 33;
            ":": return 34; ";": return 37; ".": return 38; ",": return 40;
            "$": return 41; "#": return 42;
            default: return 0;
        endcase
    endfunction

    function automatic bit may_pair(logic [7:0] c);
        return c == "+" || c == "-" || c == "&" || c == "|" || c == "!" ||
               c == "<" || c == ">" || c == "=" || c == ":" || c == ".";
    endfunction

    function automatic logic [5:0] double_op(logic [7:0] p, logic [7:0] b);
        case (p)
            "+": return b == "=" ? 31 : (b == "+" ? 15 : 0);
            "-": return b == ">" ? 36 : (b == "=" ? 32 : (b == "-" ? 16 : 0));
            "&": return b == "&" ? 22 : 0;
            "|": return b == "|" ? 21 : 0;
            "!": return b == "=" ? 25 : 0;
            "<": return b == "=" ? 27 : 0;
            ">": return b == "=" ? 29 : 0;
            "=": return b == "=" ? 24 : 0;
            ":": return b == ":" ? 35 : 0;
            ".": return b == "^" ? 39 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic void emit(logic [5:0] k, logic [1:0] e, logic [30:0] iv, logic bv,
                                 logic [31:0] ss, logic [7:0] sl, logic [23:0] ln,
                                 logic [16:0] cl);
        token_t t;
        if (step_tokens.size() >= PUSH_MAX) return;
        t = '{kind: k, err: e, ival: iv, bval: bv, sstart: ss, slen: sl, line: ln,
              col: cl, file: src_id, last: 1'b0};
        step_tokens.push_back(t);
    endfunction

    function automatic void emit_err(logic [1:0] e);
        emit(KIND_ERR, e, '0, 1'b0, '0, '0, line_cnt, {1'b0, col_cnt});
    endfunction

    function automatic void emit_at_start(logic [5:0] k);
        emit(k, ERR_NONE, '0, 1'b0, '0, '0, st_line, {1'b0, st_col});
    endfunction

    function automatic bit commented();
        return depth > 0 || in_line_cmt;
    endfunction

    function automatic void bump();
        if (col_cnt < COL_MAX) col_cnt++;
        offset++;
    endfunction

    function automatic void mark(logic [31:0] here);
        st_line = line_cnt;
        st_col  = col_cnt;
        st_off  = here;
    endfunction

    // close an open identifier or number, resolving keywords
    function automatic void close_word();
        string s;
        logic [5:0] k;
        logic v;
        s = "";
        k = KIND_SYM;
        v = 1'b0;
        if (open_kind == ACC_SYM) begin
            if (word_len <= 7)
                for (int i = 0; i < word_len; i++) s = {s, string'(word_chars[i])};
            case (s)
                "fn":      k = 43;
                "if":      k = 47;
                "else":    k = 48;
                "return":  k = 46;
                "struct":  k = 44;
                "foreign": k = 45;
                "while":   k = 49;
                "true":    begin k = KIND_BOOL; v = 1'b1; end
                "false":   k = KIND_BOOL;
                default:   k = KIND_SYM;
            endcase
            if (k == KIND_SYM)
                emit(KIND_SYM, ERR_NONE, '0, 1'b0, st_off, word_len, st_line, {1'b0, st_col});
            else
                emit(k, ERR_NONE, '0, v, '0, '0, st_line, {1'b0, st_col});
        end else if (open_kind == ACC_INT) begin
            emit(KIND_INT, ERR_NONE, num_acc, 1'b0, '0, '0, st_line, {1'b0, st_col});
        end
        open_kind = ACC_NONE;
    endfunction

    function automatic void flush_pending();
        pend_vld = 1'b0;
        if (!commented()) emit_at_start(single_op(pend_chr));
    endfunction

    function automatic void take_char(logic [7:0] c, logic [31:0] here);
        logic [5:0] k;
        if (blank_c(c)) return;
        if (c == CH_SLASH || c == CH_STAR) begin
            pend_vld = 1'b1;
            pend_chr = c;
            mark(here);
            return;
        end
        if (commented()) return;
        if (ident_first(c)) begin
            open_kind = ACC_SYM;
            foreach (word_chars[i]) word_chars[i] = 8'h00;
            word_chars[0] = c;
            word_len = 8'd1;
            mark(here);
        end else if (digit_c(c)) begin
            open_kind = ACC_INT;
            num_acc = 31'(c - "0");
            mark(here);
        end else if (may_pair(c)) begin
            pend_vld = 1'b1;
            pend_chr = c;
            mark(here);
        end else begin
            k = single_op(c);
            if (k != 0) emit(k, ERR_NONE, '0, 1'b0, '0, '0, line_cnt, {1'b0, col_cnt});
            else emit_err(ERR_SPECIAL);
        end
    endfunction

    function automatic void utf_more(logic [7:0] b);
        offset++;
        utf_code = {utf_code[9:0], b[5:0]};
        utf_left--;
        if (utf_left != 0) return;
        if (utf_code == 16'h00B4 || utf_code == 16'h2018 || utf_code == 16'h2019)
            take_char(CH_APOS, offset);
        else if (utf_code == 16'h201C || utf_code == 16'h201D || utf_code == 16'h201F ||
                 utf_code == 16'h275D || utf_code == 16'h275E)
            take_char(CH_QUOTE, offset);
        else
            emit_err(ERR_UNICODE);
    endfunction

    function automatic void new_byte(logic [7:0] b);
        logic [31:0] here;
        here = offset;
        if (b == CH_NL) begin
            col_cnt = '0;
            if (line_cnt < LINE_MAX) line_cnt++;
            in_line_cmt = 1'b0;
            offset++;
            return;
        end
        bump();
        if (b[7]) begin
            if (b[7:5] == 3'b110) begin
                utf_left = 1;
                utf_code = {11'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                utf_left = 2;
                utf_code = {12'd0, b[3:0]};
            end else begin
                emit_err(ERR_UNICODE);
            end
            return;
        end
        take_char(b, here);
    endfunction

    function automatic void clear_scan();
        line_cnt = 24'd1;
        col_cnt = '0;
        offset = '0;
        depth = 0;
        in_line_cmt = 1'b0;
        pend_vld = 1'b0;
        pend_chr = '0;
        utf_left = 0;
        utf_code = '0;
        open_kind = ACC_NONE;
        foreach (word_chars[i]) word_chars[i] = 8'h00;
        word_len = '0;
        num_acc = '0;
        st_line = '0;
        st_col = '0;
        st_off = '0;
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        logic [5:0] k;
        logic [34:0] wide;
        if (utf_left != 0) begin
            utf_more(b);
            return;
        end
        if (pend_vld) begin
            if (pend_chr == CH_SLASH && b == CH_STAR) begin
                pend_vld = 1'b0;
                if (depth < 127) depth++;
                bump();
                return;
            end
            if (pend_chr == CH_SLASH && b == CH_SLASH) begin
                pend_vld = 1'b0;
                in_line_cmt = 1'b1;
                bump();
                return;
            end
            if (pend_chr == CH_STAR && b == CH_SLASH) begin
                pend_vld = 1'b0;
                if (depth > -128) depth--;
                bump();
                if (depth < 0) emit_err(ERR_CMT_END);
                return;
            end
            k = double_op(pend_chr, b);
            if (k != 0) begin
                pend_vld = 1'b0;
                emit_at_start(k);
                bump();
                return;
            end
            flush_pending();
        end else if (open_kind == ACC_SYM) begin
            if (ident_first(b) || digit_c(b)) begin
                if (word_len < 7) word_chars[word_len] = b;
                if (word_len < SLEN_MAX) word_len++;
                bump();
                return;
            end
            close_word();
        end else if (open_kind == ACC_INT) begin
            if (digit_c(b)) begin
                wide = num_acc * 35'd10 + 35'(b - "0");
                num_acc = wide > INT_MAX ? INT_MAX : wide[30:0];
                bump();
                return;
            end
            close_word();
        end
        new_byte(b);
    endfunction

    // predict the tokens of each accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            src_id = '0;
            clear_scan();
            token_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_SOURCE_ID)
                src_id = pwdata[15:0];
            if (s_tvalid && s_tready) begin
                step_tokens.delete();
                if (s_tlast) begin
                    if (pend_vld) flush_pending();
                    close_word();
                    if (utf_left != 0) emit_err(ERR_UNICODE);
                    emit(KIND_END, ERR_NONE, '0, 1'b0, '0, '0, line_cnt, COL_END);
                    clear_scan();
                end else begin
                    scan_byte(s_tdata);
                end
                if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
                foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
            end
        end
    end

    // compare each returned word with the oldest expected token
    always @(posedge aclk) begin
        token_t e;
        if (!aresetn) begin
            fails <= 0;
        end else if (m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                $error("token returned with none expected: kind %0d", m_tuser);
                fails <= fails + 1;
            end else begin
                e = token_q.pop_front();
                if (m_tuser !== e.kind ||
                    m_tdata[1:0] !== e.err || m_tdata[32:2] !== e.ival ||
                    m_tdata[33] !== e.bval || m_tdata[65:34] !== e.sstart ||
                    m_tdata[73:66] !== e.slen || m_tdata[97:74] !== e.line ||
                    m_tdata[114:98] !== e.col || m_tdata[130:115] !== e.file ||
                    m_tlast !== e.last)
                    fails <= fails + 1;
                if (m_tuser !== e.kind)
                    $error("token_kind expected %0d got %0d", e.kind, m_tuser);
                if (m_tdata[1:0] !== e.err)
                    $error("error_code expected %0d got %0d", e.err, m_tdata[1:0]);
                if (m_tdata[32:2] !== e.ival)
                    $error("int_value expected %0d got %0d", e.ival, m_tdata[32:2]);
                if (m_tdata[33] !== e.bval)
                    $error("bool_value expected %0d got %0d", e.bval, m_tdata[33]);
                if (m_tdata[65:34] !== e.sstart)
                    $error("symbol_start expected %0d got %0d", e.sstart, m_tdata[65:34]);
                if (m_tdata[73:66] !== e.slen)
                    $error("symbol_length expected %0d got %0d", e.slen, m_tdata[73:66]);
                if (m_tdata[97:74] !== e.line)
                    $error("line_number expected %0d got %0d", e.line, m_tdata[97:74]);
                if (m_tdata[114:98] !== e.col)
                    $error("column_number expected %h got %h", e.col, m_tdata[114:98]);
                if (m_tdata[130:115] !== e.file)
                    $error("token_file expected %h got %h", e.file, m_tdata[130:115]);
                if (m_tlast !== e.last)
                    $error("last_result expected %0d got %0d", e.last, m_tlast);
            end
        end
    end

endmodule

@@ tb/sv/source_text_tokenizer_tb.sv @@
module source_text_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [5:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fails;
    int tokens_due;
    int gap_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    always #5 aclk = ~aclk;

    source_text_tokenizer dut (.*);

    source_text_tokenizer_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .fails(fails), .outstanding(tokens_due)
    );

    // random receiver stalls
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // present one word and hold it until taken
    task automatic push_word(input logic [7:0] b, input logic eot);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
    endtask

    task automatic push_end();
        push_word(8'($urandom), 1'b1);
    endtask

    // drop valid and wait for every expected token, plus settle time
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tokens_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_source_id(input logic [15:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= {16'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one random fragment, mostly well-formed text
    task automatic push_fragment();
        string words[12] = '{"fn ", "if ", "else", "return ", "struct", "foreign ",
                             "while", "true", "false ", "x_1 ", "2147483648 ", "42"};
        string ops[16] = '{"++", "--", "+=", "-=", "->", "&&", "||", "!=", "<=", ">=",
                           "==", "::", ".^", "(", ")", ";"};
        int n;
        case ($urandom_range(9))
            0, 1: push_text(words[$urandom_range(11)]);
            2, 3: push_text(ops[$urandom_range(15)]);
            4: begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    push_word("a" + 8'($urandom_range(25)), 1'b0);
                push_text(" ");
            end
            5: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) push_word("0" + 8'($urandom_range(9)), 1'b0);
            end
            6: push_text($urandom_range(1) ? "/* c */" : "// c\n");
            7: begin
                push_word(8'hE2, 1'b0);
                push_word(8'h80, 1'b0);
                push_word(8'h98 + 8'($urandom_range(7)), 1'b0);
            end
            8: push_text($urandom_range(1) ? "\n" : " ");
            default: push_word(8'($urandom), 1'b0);
        endcase
    endtask

    initial begin
        int gaps[4]   = '{0, 58, 0, 36};
        int stalls[4] = '{0, 0, 58, 36};
        logic [15:0] ids[4] = '{16'h0000, 16'h1234, 16'h0001, 16'hA5C3};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        write_source_id(16'hFFFF);
        push_text("fn true false\n");
        push_text("2147483648 +=->&&<=::.^%$@");
        push_word(8'h00, 1'b0);
        push_word(8'hE2, 1'b0); push_word(8'h80, 1'b0); push_word(8'h9C, 1'b0);
        push_word(8'hC2, 1'b0); push_word(8'hB4, 1'b0);
        push_word(8'hC3, 1'b0); push_word(8'hA9, 1'b0);
        push_word(8'h80, 1'b0); push_word(8'hF0, 1'b0); push_word(8'hFF, 1'b0);
        push_text("*/ /* a */ // d\nx");
        push_end();
        push_text("+");
        push_end();
        push_word(8'hE2, 1'b0);
        push_end();
        drain();

        // random part, four phases with different gap and stall rates
        for (int p = 0; p < 4; p++) begin
            write_source_id(ids[p] ^ 16'($urandom_range(1) ? 0 : $urandom));
            gap_pct = gaps[p];
            stall_pct = stalls[p];
            for (int i = 0; i < 3; i++) begin
                push_fragment();
                if ($urandom_range(15) == 0) push_end();
            end
            push_end();
            drain();
        end

        if (fails == 0 && tokens_due == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
